### src/trm_pkg.sv
`timescale 1ns / 1ps

package trm_pkg;

    localparam int NUM_REGS  = 5;
    localparam int MEM_WORDS = 64;
    localparam int MAX_LINES = 1024;

    localparam int REG_AW = $clog2(NUM_REGS);
    localparam int MEM_AW = $clog2(MEM_WORDS);
    localparam int DATA_W = 32;
    localparam int LINE_W = 11;
    localparam int IDX_W  = 6;
    localparam int KIND_W = 2;
    localparam int FUNC_W = 3;
    localparam int ERR_W  = 3;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_MOV = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SUB = 3'd2;
    localparam logic [FUNC_W-1:0] FN_JMP = 3'd3;
    localparam logic [FUNC_W-1:0] FN_JPN = 3'd4;
    localparam logic [FUNC_W-1:0] FN_PRN = 3'd5;
    localparam logic [FUNC_W-1:0] FN_HLT = 3'd6;

    // operand kinds
    localparam logic [KIND_W-1:0] KD_REG   = 2'd0;
    localparam logic [KIND_W-1:0] KD_MEM   = 2'd1;
    localparam logic [KIND_W-1:0] KD_CONST = 2'd2;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK   = 3'd0;
    localparam logic [ERR_W-1:0] ERR_REG  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_MEM  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_LINE = 3'd3;
    localparam logic [ERR_W-1:0] ERR_COMB = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KIND_W-1:0] first_kind;
        logic [IDX_W-1:0]  first_index;
        logic [KIND_W-1:0] second_kind;
        logic [IDX_W-1:0]  second_index;
        logic [DATA_W-1:0] immediate;
        logic [LINE_W-1:0] current_line;
    } item_t;

    // one write-back: register file or data memory, never both
    typedef struct packed {
        logic              reg_en;
        logic              mem_en;
        logic [REG_AW-1:0] reg_addr;
        logic [MEM_AW-1:0] mem_addr;
        logic [DATA_W-1:0] data;
    } wrb_t;

    typedef struct packed {
        logic [LINE_W-1:0]        next_line;
        logic                     halted;
        logic [ERR_W-1:0]         error_code;
        logic                     print_valid;
        logic signed [DATA_W-1:0] print_value;
    } res_t;

    // register numbers are one-based
    function automatic logic [REG_AW-1:0] reg_addr(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] zb;
        zb = idx - IDX_W'(1);
        return REG_AW'(zb);
    endfunction

    // at most one operand is a memory word; the first wins
    function automatic logic [MEM_AW-1:0] mem_rd_addr(input item_t it);
        return (it.first_kind == KD_MEM) ? MEM_AW'(it.first_index)
                                         : MEM_AW'(it.second_index);
    endfunction

endpackage

### src/trm_regfile.sv
`timescale 1ns / 1ps

module trm_regfile (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [trm_pkg::REG_AW-1:0]    rd_a_addr,
    input  logic [trm_pkg::REG_AW-1:0]    rd_b_addr,
    output logic [trm_pkg::DATA_W-1:0]    rd_a_data,
    output logic [trm_pkg::DATA_W-1:0]    rd_b_data,
    input  logic                          wr_en,
    input  logic [trm_pkg::REG_AW-1:0]    wr_addr,
    input  logic [trm_pkg::DATA_W-1:0]    wr_data
);
    import trm_pkg::*;

    logic [DATA_W-1:0]   mem_reg [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [DATA_W-1:0]   rd_a_reg;
    logic [DATA_W-1:0]   rd_b_reg;

    // an entry never written reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg <= valid_reg[rd_a_addr] ? mem_reg[rd_a_addr] : '0;
            rd_b_reg <= valid_reg[rd_b_addr] ? mem_reg[rd_b_addr] : '0;
        end
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

### src/trm_dmem.sv
`timescale 1ns / 1ps

module trm_dmem (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [trm_pkg::MEM_AW-1:0]    rd_addr,
    output logic [trm_pkg::DATA_W-1:0]    rd_data,
    input  logic                          wr_en,
    input  logic [trm_pkg::MEM_AW-1:0]    wr_addr,
    input  logic [trm_pkg::DATA_W-1:0]    wr_data
);
    import trm_pkg::*;

    logic [DATA_W-1:0]    mem_reg [MEM_WORDS];
    logic [MEM_WORDS-1:0] valid_reg;
    logic [DATA_W-1:0]    rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_reg <= valid_reg[rd_addr] ? mem_reg[rd_addr] : '0;
        end
    end

    assign rd_data = rd_reg;

endmodule

### src/trm_exec.sv
`timescale 1ns / 1ps

module trm_exec (
    input  trm_pkg::item_t                it,
    input  logic [trm_pkg::DATA_W-1:0]    reg_a_raw,
    input  logic [trm_pkg::DATA_W-1:0]    reg_b_raw,
    input  logic [trm_pkg::DATA_W-1:0]    mem_raw,
    input  trm_pkg::wrb_t                 byp,
    input  logic [trm_pkg::LINE_W-1:0]    program_lines,
    output trm_pkg::wrb_t                 wr,
    output trm_pkg::res_t                 res
);
    import trm_pkg::*;

    function automatic logic [ERR_W-1:0] check_operand(input logic [KIND_W-1:0] kind,
                                                       input logic [IDX_W-1:0]  idx);
        logic [ERR_W-1:0] e;
        case (kind)
            KD_REG:   e = (idx != '0 && 32'(idx) <= NUM_REGS) ? ERR_OK : ERR_REG;
            KD_MEM:   e = (32'(idx) < MEM_WORDS) ? ERR_OK : ERR_MEM;
            KD_CONST: e = ERR_OK;
            default:  e = ERR_COMB;
        endcase
        return e;
    endfunction

    logic [DATA_W-1:0] reg_a, reg_b, mem_d, fa, sb, limit, wdata;
    logic [ERR_W-1:0]  fchk, schk, err;
    logic [KIND_W-1:0] wk;
    logic [IDX_W-1:0]  widx;
    logic [LINE_W-1:0] next;
    logic              we, taken, tgt_ok, sk_bad, halt, pv;

    // take the write that landed in the same cycle as this item's read
    always_comb begin
        reg_a = (byp.reg_en && byp.reg_addr == reg_addr(it.first_index))
                ? byp.data : reg_a_raw;
        reg_b = (byp.reg_en && byp.reg_addr == reg_addr(it.second_index))
                ? byp.data : reg_b_raw;
        mem_d = (byp.mem_en && byp.mem_addr == mem_rd_addr(it)) ? byp.data : mem_raw;
    end

    always_comb begin
        fchk   = check_operand(it.first_kind, it.first_index);
        schk   = check_operand(it.second_kind, it.second_index);
        fa     = (it.first_kind == KD_REG) ? reg_a :
                 (it.first_kind == KD_MEM) ? mem_d : it.immediate;
        sb     = (it.second_kind == KD_REG) ? reg_b :
                 (it.second_kind == KD_MEM) ? mem_d : it.immediate;
        sk_bad = it.second_kind != KD_REG && it.second_kind != KD_MEM &&
                 it.second_kind != KD_CONST;
        limit  = (32'(program_lines) > 32'(MAX_LINES)) ? 32'(MAX_LINES)
                                                      : 32'(program_lines);
        tgt_ok = !it.immediate[DATA_W-1] && it.immediate != '0 && it.immediate <= limit;
    end

    always_comb begin
        err   = ERR_OK;
        halt  = 1'b0;
        pv    = 1'b0;
        next  = it.current_line + LINE_W'(1);
        we    = 1'b0;
        wk    = KD_REG;
        widx  = it.first_index;
        wdata = it.immediate;
        taken = 1'b0;
        unique case (it.func) inside
            FN_MOV: begin
                if ((it.first_kind != KD_REG && it.first_kind != KD_MEM) || sk_bad ||
                    (it.first_kind == KD_MEM && it.second_kind == KD_MEM)) begin
                    err = ERR_COMB;
                end else if (fchk != ERR_OK) begin
                    err = fchk;
                end else if (schk != ERR_OK) begin
                    err = schk;
                end else if (it.second_kind == KD_CONST) begin
                    we = 1'b1;
                    wk = it.first_kind;
                end else begin
                    we    = 1'b1;
                    wk    = it.second_kind;
                    widx  = it.second_index;
                    wdata = fa;
                end
            end
            FN_ADD, FN_SUB: begin
                if (it.first_kind != KD_REG || sk_bad) begin
                    err = ERR_COMB;
                end else if (fchk != ERR_OK) begin
                    err = fchk;
                end else if (schk != ERR_OK) begin
                    err = schk;
                end else begin
                    we    = 1'b1;
                    wdata = (it.func == FN_ADD) ? fa + sb : fa - sb;
                end
            end
            FN_JMP, FN_JPN: begin
                if (it.first_kind == KD_REG) begin
                    err   = fchk;
                    taken = (it.func == FN_JMP) ? (reg_a == '0)
                                                : (reg_a == '0 || reg_a[DATA_W-1]);
                end else if (it.first_kind == KD_CONST) begin
                    taken = 1'b1;
                end else begin
                    err = ERR_COMB;
                end
                if (err == ERR_OK && !tgt_ok) begin
                    err = ERR_LINE;
                end
                if (taken) begin
                    next = it.immediate[LINE_W-1:0];
                end
            end
            FN_PRN: begin
                err = fchk;
                pv  = 1'b1;
            end
            FN_HLT: begin
                halt = 1'b1;
                next = it.current_line;
            end
            default: err = ERR_COMB;
        endcase
        // an error stops the machine and leaves the state alone
        if (err != ERR_OK) begin
            halt = 1'b1;
            next = it.current_line;
            pv   = 1'b0;
            we   = 1'b0;
        end
    end

    always_comb begin
        wr.reg_en   = we && wk == KD_REG;
        wr.mem_en   = we && wk == KD_MEM;
        wr.reg_addr = reg_addr(widx);
        wr.mem_addr = MEM_AW'(widx);
        wr.data     = wdata;

        res.next_line   = next;
        res.halted      = halt;
        res.error_code  = err;
        res.print_valid = pv;
        res.print_value = pv ? $signed(fa) : '0;
    end

endmodule

### src/tiny_register_machine_execute.sv
`timescale 1ns / 1ps
// Execute stage of a small five-register machine with a 64-word data memory.
// s_ channel: one decoded instruction per item. func travels in s_tuser, the
// operands, constant and current line in s_tdata.
// m_ channel: one result item per instruction, in order: next line, error
// code and printed value in m_tdata, halted and print_valid flags in m_tuser.
// cfg_ channel: writes program_lines (limit for jump targets); it is always
// ready. The user must see that it is used only while no instruction is in
// flight; the block itself does not enforce this.
// The register file and memory reads are registered with the accepted
// instruction; execute writes back into the output register.
// Throughput: one instruction per cycle absent a stall; a write-back landing
// with the next read is forwarded, so back-to-back dependants run freely.
// Reset (aresetn low, synchronous): the pipeline empties, program_lines goes
// to 1 and the valid bits of both stores clear, so every register and memory
// word reads as zero until written.
// A stalled receiver holds m_tdata and m_tuser; one more instruction waits in
// the execute stage, after which s_tready drops until the output drains.
module tiny_register_machine_execute (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [trm_pkg::LINE_W-1:0]     cfg_data,      // program_lines
    // instruction items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [1:0] first_kind, [7:2] first_index, [9:8] second_kind,
    // [15:10] second_index, [47:16] immediate, [58:48] current_line
    input  logic [63:0]                    s_tdata,
    input  logic [2:0]                     s_tuser,       // [2:0] func
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [10:0] next_line, [13:11] error_code, [45:14] print_value
    output logic [47:0]                    m_tdata,
    output logic [1:0]                     m_tuser        // [0] halted, [1] print_valid
);
    import trm_pkg::*;

    item_t             s_item;
    item_t             s1_item_reg;
    logic              s1_valid_reg;
    wrb_t              byp_reg, byp_next, wr;
    res_t              res, m_res_reg;
    logic              m_valid_reg;
    logic [LINE_W-1:0] prog_lines_reg;
    logic [DATA_W-1:0] reg_a_raw, reg_b_raw, mem_raw;
    logic              s_accept, s1_fire;

    // unpack the incoming item
    always_comb begin
        s_item.func         = s_tuser;
        s_item.first_kind   = s_tdata[1:0];
        s_item.first_index  = s_tdata[7:2];
        s_item.second_kind  = s_tdata[9:8];
        s_item.second_index = s_tdata[15:10];
        s_item.immediate    = s_tdata[47:16];
        s_item.current_line = s_tdata[58:48];
    end

    // advance the execute stage whenever the output register is free or draining
    assign s1_fire  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign s_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prog_lines_reg <= LINE_W'(1);
        end else if (cfg_valid) begin
            prog_lines_reg <= cfg_data;
        end
    end

    // stores: read with the accepted item, written when its successor stage fires
    trm_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (s_accept),
        .rd_a_addr (reg_addr(s_item.first_index)),
        .rd_b_addr (reg_addr(s_item.second_index)),
        .rd_a_data (reg_a_raw),
        .rd_b_data (reg_b_raw),
        .wr_en     (s1_fire && wr.reg_en),
        .wr_addr   (wr.reg_addr),
        .wr_data   (wr.data)
    );

    trm_dmem u_dmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd_addr (mem_rd_addr(s_item)),
        .rd_data (mem_raw),
        .wr_en   (s1_fire && wr.mem_en),
        .wr_addr (wr.mem_addr),
        .wr_data (wr.data)
    );

    trm_exec u_exec (
        .it            (s1_item_reg),
        .reg_a_raw     (reg_a_raw),
        .reg_b_raw     (reg_b_raw),
        .mem_raw       (mem_raw),
        .byp           (byp_reg),
        .program_lines (prog_lines_reg),
        .wr            (wr),
        .res           (res)
    );

    // record the write that lands on the same edge as a new read
    always_comb begin
        byp_next        = wr;
        byp_next.reg_en = s1_fire && wr.reg_en;
        byp_next.mem_en = s1_fire && wr.mem_en;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            byp_reg.reg_en <= 1'b0;
            byp_reg.mem_en <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
                byp_reg      <= byp_next;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_item_reg <= s_item;
        end
    end

    // output register: hold while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_res_reg.print_value, m_res_reg.error_code,
                       m_res_reg.next_line};
    assign m_tuser  = {m_res_reg.print_valid, m_res_reg.halted};

endmodule
